FILE: hw/rtl/aabb_frustum_cull_core_assert.svh
// ---------------------------------------------------------------------------
// aabb_frustum_cull_core_assert: assertion macros
// shared concurrent check forms, clocked on clk and disabled in rst
// ---------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_CORE_ASSERT_SVH
`define AABB_FRUSTUM_CULL_CORE_ASSERT_SVH

// condition implies property in the same cycle
`define AFC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("afc check failed in the same cycle");

// condition implies property in the next cycle
`define AFC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("afc check failed one cycle later");

`endif

FILE: hw/rtl/afc_pkg.sv
// ---------------------------------------------------------------------------
// afc_pkg: shared types and constants
// widths of the fixed-point plane test and the verdict codes
// ---------------------------------------------------------------------------
package afc_pkg;

  localparam int REG_PLANES     = 6;
  localparam int NUM_PLANES_DEF = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int COORD_W = 22;   // signed Q18.4
  localparam int HALF_W  = 21;   // unsigned Q17.4
  localparam int NORM_W  = 14;   // signed Q2.12
  localparam int DIST_W  = 22;   // signed Q18.4
  localparam int FRAC_N  = 12;   // normal fraction bits

  localparam int CPROD_W = COORD_W + NORM_W;   // signed center product
  localparam int HPROD_W = HALF_W + NORM_W;    // unsigned radius product
  localparam int RAD_W   = HPROD_W + 2;        // sum of three radius products
  localparam int OFF_W   = CPROD_W + 4;        // offset and offset +/- radius

  localparam int MASK_W = 6;
  localparam int FAIL_W = 3;

  // plane word packing
  localparam int NX_LSB = 0;
  localparam int NY_LSB = 14;
  localparam int NZ_LSB = 28;
  localparam int D_LSB  = 42;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE   = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_INSIDE    = 2'd2
  } verdict_t;

  // stage advance strobes shared by every plane lane
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } stage_ctl_t;

endpackage

FILE: hw/rtl/afc_plane_test.sv
// ---------------------------------------------------------------------------
// afc_plane_test: one plane lane
// products, offset and radius sums, then the outside and inside compares
// ---------------------------------------------------------------------------
module afc_plane_test (
  input  logic                                clk,
  input  afc_pkg::stage_ctl_t                 ctl,
  input  logic [afc_pkg::CFG_DATA_W-1:0]      plane,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_x,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_y,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_z,
  input  logic [afc_pkg::HALF_W-1:0]          half_x,
  input  logic [afc_pkg::HALF_W-1:0]          half_y,
  input  logic [afc_pkg::HALF_W-1:0]          half_z,
  output logic                                outside,
  output logic                                enclosed
);

  logic signed [afc_pkg::NORM_W-1:0] nx, ny, nz;
  logic [afc_pkg::NORM_W-1:0]        ax, ay, az;
  logic signed [afc_pkg::DIST_W-1:0] plane_d;

  // stage 1
  logic signed [afc_pkg::CPROD_W-1:0] cpx, cpy, cpz;
  logic [afc_pkg::HPROD_W-1:0]        hpx, hpy, hpz;
  logic signed [afc_pkg::DIST_W-1:0]  d1;

  // stage 2
  logic signed [afc_pkg::OFF_W-1:0] off;
  logic [afc_pkg::RAD_W-1:0]        rad;

  logic signed [afc_pkg::OFF_W-1:0] rad_s, lo_sum, hi_diff;

  assign nx      = plane[afc_pkg::NX_LSB +: afc_pkg::NORM_W];
  assign ny      = plane[afc_pkg::NY_LSB +: afc_pkg::NORM_W];
  assign nz      = plane[afc_pkg::NZ_LSB +: afc_pkg::NORM_W];
  assign plane_d = plane[afc_pkg::D_LSB +: afc_pkg::DIST_W];

  // magnitude fits the unsigned width, including the most negative normal
  assign ax = nx[afc_pkg::NORM_W-1] ? afc_pkg::NORM_W'(-nx) : afc_pkg::NORM_W'(nx);
  assign ay = ny[afc_pkg::NORM_W-1] ? afc_pkg::NORM_W'(-ny) : afc_pkg::NORM_W'(ny);
  assign az = nz[afc_pkg::NORM_W-1] ? afc_pkg::NORM_W'(-nz) : afc_pkg::NORM_W'(nz);

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      cpx <= center_x * nx;
      cpy <= center_y * ny;
      cpz <= center_z * nz;
      hpx <= half_x * ax;
      hpy <= half_y * ay;
      hpz <= half_z * az;
      d1  <= plane_d;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      off <= afc_pkg::OFF_W'(cpx) + afc_pkg::OFF_W'(cpy) + afc_pkg::OFF_W'(cpz)
             - afc_pkg::OFF_W'($signed({d1, {afc_pkg::FRAC_N{1'b0}}}));
      rad <= afc_pkg::RAD_W'(hpx) + afc_pkg::RAD_W'(hpy) + afc_pkg::RAD_W'(hpz);
    end
  end

  assign rad_s   = $signed({{(afc_pkg::OFF_W-afc_pkg::RAD_W){1'b0}}, rad});
  assign lo_sum  = off + rad_s;
  assign hi_diff = off - rad_s;

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      outside  <= lo_sum[afc_pkg::OFF_W-1];
      enclosed <= !hi_diff[afc_pkg::OFF_W-1] && (hi_diff != '0);
    end
  end

endmodule

FILE: hw/rtl/afc_resolve.sv
// ---------------------------------------------------------------------------
// afc_resolve: verdict and fail-plane selection
// combines the per-plane flags in test order and registers the result
// ---------------------------------------------------------------------------
module afc_resolve #(
  parameter int USED_PLANES = afc_pkg::NUM_PLANES_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [afc_pkg::MASK_W-1:0]    plane_mask,
  input  logic [afc_pkg::FAIL_W-1:0]    prev_fail_plane,
  input  logic [afc_pkg::REG_PLANES-1:0] outside,
  input  logic [afc_pkg::REG_PLANES-1:0] enclosed,
  output afc_pkg::verdict_t             verdict,
  output logic [afc_pkg::MASK_W-1:0]    intersect_mask,
  output logic [afc_pkg::FAIL_W-1:0]    fail_plane
);

  logic [afc_pkg::REG_PLANES-1:0] used_mask;
  logic [afc_pkg::REG_PLANES-1:0] tested, reject, straddle;
  logic                           prev_ok, prev_rej;
  logic [afc_pkg::FAIL_W-1:0]     first_rej;
  afc_pkg::verdict_t              verdict_next;
  logic [afc_pkg::MASK_W-1:0]     imask_next;
  logic [afc_pkg::FAIL_W-1:0]     fail_next;

  always_comb begin
    for (int i = 0; i < afc_pkg::REG_PLANES; i++) begin
      used_mask[i] = (i < USED_PLANES);
    end
  end

  assign tested   = plane_mask & used_mask;
  assign reject   = tested & outside;
  assign straddle = tested & ~outside & ~enclosed;
  assign prev_ok  = prev_fail_plane < afc_pkg::FAIL_W'(USED_PLANES);
  assign prev_rej = prev_ok && reject[prev_fail_plane];

  // lowest rejecting index; the loop runs from the top plane down, so the lowest wins
  always_comb begin
    first_rej = prev_fail_plane;
    for (int i = afc_pkg::REG_PLANES - 1; i >= 0; i--) begin
      if (reject[i]) begin
        first_rej = afc_pkg::FAIL_W'(i);
      end
    end
  end

  always_comb begin
    if (reject != '0) begin
      verdict_next = afc_pkg::VERDICT_OUTSIDE;
      imask_next   = '0;
      fail_next    = prev_rej ? prev_fail_plane : first_rej;
    end else begin
      verdict_next = (straddle != '0) ? afc_pkg::VERDICT_INTERSECT : afc_pkg::VERDICT_INSIDE;
      imask_next   = straddle;
      fail_next    = prev_fail_plane;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict        <= verdict_next;
      intersect_mask <= imask_next;
      fail_plane     <= fail_next;
    end
  end

endmodule

FILE: hw/rtl/aabb_frustum_cull_core.sv
// ---------------------------------------------------------------------------
// aabb_frustum_cull_core: box against frustum planes, one lane per plane
// registered lane products, sums, compares, then resolve, lead to out_valid
// one box accepted per cycle; only out_stall holds back the input
// rst clears every stage valid and all plane registers to zero
// ---------------------------------------------------------------------------
`include "aabb_frustum_cull_core_assert.svh"

module aabb_frustum_cull_core #(
  parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0]      cfg_data,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_x,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_y,
  input  logic signed [afc_pkg::COORD_W-1:0]  center_z,
  input  logic [afc_pkg::HALF_W-1:0]          half_x,
  input  logic [afc_pkg::HALF_W-1:0]          half_y,
  input  logic [afc_pkg::HALF_W-1:0]          half_z,
  input  logic [afc_pkg::MASK_W-1:0]          plane_mask,
  input  logic [afc_pkg::FAIL_W-1:0]          prev_fail_plane,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          verdict,
  output logic [afc_pkg::MASK_W-1:0]          intersect_mask,
  output logic [afc_pkg::FAIL_W-1:0]          fail_plane
);

  localparam int USED_PLANES =
    (NUM_PLANES < afc_pkg::REG_PLANES) ? NUM_PLANES : afc_pkg::REG_PLANES;

  logic [afc_pkg::CFG_DATA_W-1:0] planes [USED_PLANES];

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  logic load_out;
  afc_pkg::stage_ctl_t ctl;

  logic [afc_pkg::MASK_W-1:0] mask1, mask2, mask3;
  logic [afc_pkg::FAIL_W-1:0] prev1, prev2, prev3;

  logic [afc_pkg::REG_PLANES-1:0] outside, enclosed;
  afc_pkg::verdict_t              verdict_q;

  // plane registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < USED_PLANES; i++) begin
      if (rst) begin
        planes[i] <= '0;
      end else if (cfg_we && cfg_index == afc_pkg::CFG_IDX_W'(i)) begin
        planes[i] <= cfg_data;
      end
    end
  end

  // a stage moves when it is empty or the next one moves
  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign ctl.adv1 = in_valid && rdy1;
  assign ctl.adv2 = v1 && rdy2;
  assign ctl.adv3 = v2 && rdy3;
  assign load_out = v3 && rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      mask1 <= plane_mask;
      prev1 <= prev_fail_plane;
    end
    if (ctl.adv2) begin
      mask2 <= mask1;
      prev2 <= prev1;
    end
    if (ctl.adv3) begin
      mask3 <= mask2;
      prev3 <= prev2;
    end
  end

  for (genvar g = 0; g < afc_pkg::REG_PLANES; g++) begin : g_lane
    if (g < USED_PLANES) begin : g_used
      afc_plane_test u_lane (
        .clk      (clk),
        .ctl      (ctl),
        .plane    (planes[g]),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .half_x   (half_x),
        .half_y   (half_y),
        .half_z   (half_z),
        .outside  (outside[g]),
        .enclosed (enclosed[g])
      );
    end else begin : g_unused
      assign outside[g]  = 1'b0;
      assign enclosed[g] = 1'b0;
    end
  end

  afc_resolve #(
    .USED_PLANES (USED_PLANES)
  ) u_resolve (
    .clk             (clk),
    .load            (load_out),
    .plane_mask      (mask3),
    .prev_fail_plane (prev3),
    .outside         (outside),
    .enclosed        (enclosed),
    .verdict         (verdict_q),
    .intersect_mask  (intersect_mask),
    .fail_plane      (fail_plane)
  );

  assign verdict = verdict_q;

  `AFC_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v1)
  `AFC_ASSERT_NOW(a_outside_no_mask, out_valid && verdict_q == afc_pkg::VERDICT_OUTSIDE,
    intersect_mask == '0)
  `AFC_ASSERT_NOW(a_intersect_has_mask, out_valid && verdict_q == afc_pkg::VERDICT_INTERSECT,
    intersect_mask != '0)
  `AFC_ASSERT_NOW(a_inside_no_mask, out_valid && verdict_q == afc_pkg::VERDICT_INSIDE,
    intersect_mask == '0)
  `AFC_ASSERT_NOW(a_fail_in_range, out_valid && verdict_q == afc_pkg::VERDICT_OUTSIDE,
    fail_plane < afc_pkg::FAIL_W'(USED_PLANES))

endmodule
